FILE: rtl/rtc3w_pkg.sv
`timescale 1ns / 1ps

package rtc3w_pkg;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_READ_REQ  = 2'd1,
    OP_WRITE_REQ = 2'd2,
    OP_GRANT     = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] address;
    logic [6:0] write_value;
    logic       io_in;
  } in_word_t;

  typedef struct packed {
    logic       sck;
    logic       io_out;
    logic       io_drive;
    logic       chip_enable;
    logic       writing;
    logic       reading;
    logic       done_res;
    logic       done_is_read;
    logic [7:0] done_address;
    logic [7:0] read_raw;
    logic [6:0] read_value;
  } out_word_t;

  // Binary to packed BCD by one trial subtraction per tens weight; the
  // remainder is ORed in, so values above 79 leave a remainder above 9 and give no valid BCD.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [6:0] rem;
    logic [7:0] r;
    rem = v;
    r   = 8'h00;
    if (rem >= 7'd40) begin
      r   = r | 8'h40;
      rem = rem - 7'd40;
    end
    if (rem >= 7'd20) begin
      r   = r | 8'h20;
      rem = rem - 7'd20;
    end
    if (rem >= 7'd10) begin
      r   = r | 8'h10;
      rem = rem - 7'd10;
    end
    r = r | {1'b0, rem};
    return r;
  endfunction

  // Weights 40/20/10 for bits 6..4 plus the low nibble; bit 7 is ignored.
  function automatic logic [6:0] from_bcd(input logic [7:0] b);
    logic [6:0] r;
    r = {3'b000, b[3:0]};
    if (b[6]) r = r + 7'd40;
    if (b[5]) r = r + 7'd20;
    if (b[4]) r = r + 7'd10;
    return r;
  endfunction

endpackage

FILE: rtl/rtc3w_engine.sv
`timescale 1ns / 1ps

module rtc3w_engine import rtc3w_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_word_t  item,
  output out_word_t result
);

  logic [3:0] bit_count_r,     bit_count_nxt;
  logic       address_done_r,  address_done_nxt;
  logic       clock_level_r,   clock_level_nxt;
  logic       data_level_r,    data_level_nxt;
  logic       drive_enable_r,  drive_enable_nxt;
  logic       select_level_r,  select_level_nxt;
  logic       active_write_r,  active_write_nxt;
  logic       active_read_r,   active_read_nxt;
  logic       pending_read_r,  pending_read_nxt;
  logic       pending_write_r, pending_write_nxt;
  logic [7:0] pend_rd_addr_r,  pend_rd_addr_nxt;
  logic [7:0] pend_wr_addr_r,  pend_wr_addr_nxt;
  logic [7:0] pend_wr_byte_r,  pend_wr_byte_nxt;
  logic [7:0] cur_addr_r,      cur_addr_nxt;
  logic [7:0] cur_byte_r,      cur_byte_nxt;
  logic [7:0] rx_byte_r,       rx_byte_nxt;

  logic       done;
  logic       done_read;
  logic [7:0] done_addr;
  logic [3:0] count_inc;
  logic [2:0] bit_sel;

  assign count_inc = bit_count_r + 4'd1;
  assign bit_sel   = bit_count_r[2:0];

  always_comb begin
    bit_count_nxt     = bit_count_r;
    address_done_nxt  = address_done_r;
    clock_level_nxt   = clock_level_r;
    data_level_nxt    = data_level_r;
    drive_enable_nxt  = drive_enable_r;
    select_level_nxt  = select_level_r;
    active_write_nxt  = active_write_r;
    active_read_nxt   = active_read_r;
    pending_read_nxt  = pending_read_r;
    pending_write_nxt = pending_write_r;
    pend_rd_addr_nxt  = pend_rd_addr_r;
    pend_wr_addr_nxt  = pend_wr_addr_r;
    pend_wr_byte_nxt  = pend_wr_byte_r;
    cur_addr_nxt      = cur_addr_r;
    cur_byte_nxt      = cur_byte_r;
    rx_byte_nxt       = rx_byte_r;
    done              = 1'b0;
    done_read         = 1'b0;
    done_addr         = 8'h00;

    unique case (item.op)
      OP_READ_REQ: begin
        pending_read_nxt = 1'b1;
        pend_rd_addr_nxt = item.address;
      end
      OP_WRITE_REQ: begin
        pending_write_nxt = 1'b1;
        pend_wr_addr_nxt  = item.address;
        pend_wr_byte_nxt  = to_bcd(item.write_value);
      end
      OP_GRANT: begin
        if (!active_write_r && !active_read_r) begin
          if (pending_read_r) begin
            pending_read_nxt = 1'b0;
            active_read_nxt  = 1'b1;
            cur_addr_nxt     = pend_rd_addr_r;
          end else if (pending_write_r) begin
            pending_write_nxt = 1'b0;
            active_write_nxt  = 1'b1;
            cur_addr_nxt      = pend_wr_addr_r;
            cur_byte_nxt      = pend_wr_byte_r;
          end
        end
      end
      OP_TICK: begin
        if (active_write_r) begin
          clock_level_nxt = ~clock_level_r;
          if (bit_count_r[3]) begin
            // tick after the last data bit closes the transfer
            bit_count_nxt    = 4'd0;
            active_write_nxt = 1'b0;
            address_done_nxt = 1'b0;
            select_level_nxt = 1'b0;
            done             = 1'b1;
            done_addr        = cur_addr_r;
          end else if (!clock_level_r) begin
            select_level_nxt = 1'b1;
            bit_count_nxt    = count_inc;
            if (!address_done_r) begin
              data_level_nxt = cur_addr_r[bit_sel];
              if (count_inc[3]) begin
                bit_count_nxt    = 4'd0;
                address_done_nxt = 1'b1;
              end
            end else begin
              data_level_nxt = cur_byte_r[bit_sel];
            end
          end
        end else if (active_read_r) begin
          clock_level_nxt = ~clock_level_r;
          if (!clock_level_r) begin
            select_level_nxt = 1'b1;
            bit_count_nxt    = count_inc;
            if (!address_done_r) begin
              data_level_nxt = cur_addr_r[bit_sel];
              if (count_inc[3]) begin
                bit_count_nxt    = 4'd0;
                address_done_nxt = 1'b1;
              end
            end else begin
              drive_enable_nxt     = 1'b0;
              rx_byte_nxt[bit_sel] = item.io_in;
              if (count_inc[3]) begin
                bit_count_nxt    = 4'd0;
                address_done_nxt = 1'b0;
                active_read_nxt  = 1'b0;
                drive_enable_nxt = 1'b1;
                select_level_nxt = 1'b0;
                done             = 1'b1;
                done_read        = 1'b1;
                done_addr        = cur_addr_r;
              end
            end
          end
        end
      end
      default: ;
    endcase

    result.sck          = clock_level_nxt;
    result.io_out       = data_level_nxt;
    result.io_drive     = drive_enable_nxt;
    result.chip_enable  = select_level_nxt;
    result.writing      = active_write_nxt;
    result.reading      = active_read_nxt;
    result.done_res     = done;
    result.done_is_read = done_read;
    result.done_address = done_addr;
    result.read_raw     = rx_byte_nxt;
    result.read_value   = from_bcd(rx_byte_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r     <= 4'd0;
      address_done_r  <= 1'b0;
      clock_level_r   <= 1'b0;
      data_level_r    <= 1'b0;
      drive_enable_r  <= 1'b1;
      select_level_r  <= 1'b0;
      active_write_r  <= 1'b0;
      active_read_r   <= 1'b0;
      pending_read_r  <= 1'b0;
      pending_write_r <= 1'b0;
      pend_rd_addr_r  <= 8'h00;
      pend_wr_addr_r  <= 8'h00;
      pend_wr_byte_r  <= 8'h00;
      cur_addr_r      <= 8'h00;
      cur_byte_r      <= 8'h00;
      rx_byte_r       <= 8'h00;
    end else if (fire) begin
      bit_count_r     <= bit_count_nxt;
      address_done_r  <= address_done_nxt;
      clock_level_r   <= clock_level_nxt;
      data_level_r    <= data_level_nxt;
      drive_enable_r  <= drive_enable_nxt;
      select_level_r  <= select_level_nxt;
      active_write_r  <= active_write_nxt;
      active_read_r   <= active_read_nxt;
      pending_read_r  <= pending_read_nxt;
      pending_write_r <= pending_write_nxt;
      pend_rd_addr_r  <= pend_rd_addr_nxt;
      pend_wr_addr_r  <= pend_wr_addr_nxt;
      pend_wr_byte_r  <= pend_wr_byte_nxt;
      cur_addr_r      <= cur_addr_nxt;
      cur_byte_r      <= cur_byte_nxt;
      rx_byte_r       <= rx_byte_nxt;
    end
  end

endmodule

FILE: rtl/three_wire_rtc_serial_master_top.sv
`timescale 1ns / 1ps

// Three-wire serial master for an RTC chip. Each input word is a bit tick, a
// read request, a write request (value converted to packed BCD) or a service
// grant; every word yields exactly one result word with the line levels
// (sck, io_out, io_drive, chip_enable), the transfer flags, a done strobe with
// the finished address, and the last read byte raw and BCD-decoded. Throughput
// is one word per clock while out_stall is low; each input word is captured in
// the input register, and the state update writes its result word into the
// result register. The result register drains while the input register
// refills, so with out_stall low the block never stalls its source.

module three_wire_rtc_serial_master_top import rtc3w_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      in_valid_r;
  in_word_t  in_data_r;
  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t result;
  logic      out_free;
  logic      fire;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  rtc3w_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (in_data_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import rtc3w_pkg::*;

  localparam int N_ITEMS    = 1850;
  localparam int CYCLE_CAP  = 400000;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_LEN   = 300;

  // Tracks the serial master state and holds the words it should produce.
  class rtc_scoreboard;
    logic [3:0] bit_cnt;
    logic       addr_sent, sck_lvl, io_lvl, drv_en, ce_lvl;
    logic       wr_busy, rd_busy, rd_pend, wr_pend;
    logic [7:0] rd_pend_addr, wr_pend_addr, wr_pend_byte;
    logic [7:0] cur_addr, cur_byte, rx_byte;
    out_word_t  expected_q[$];
    int         errors, n_in, n_out, n_wr_done, n_rd_done;

    function new();
      bit_cnt = '0; addr_sent = 0; sck_lvl = 0; io_lvl = 0; drv_en = 1; ce_lvl = 0;
      wr_busy = 0; rd_busy = 0; rd_pend = 0; wr_pend = 0;
      rd_pend_addr = '0; wr_pend_addr = '0; wr_pend_byte = '0;
      cur_addr = '0; cur_byte = '0; rx_byte = '0;
      errors = 0; n_in = 0; n_out = 0; n_wr_done = 0; n_rd_done = 0;
    endfunction

    function logic [7:0] bcd_encode(logic [6:0] v);
      int         left;
      logic [7:0] r;
      left = v;
      r    = 8'h00;
      if (left >= 40) begin r[6] = 1'b1; left -= 40; end
      if (left >= 20) begin r[5] = 1'b1; left -= 20; end
      if (left >= 10) begin r[4] = 1'b1; left -= 10; end
      r = r | 8'(left);
      return r;
    endfunction

    function logic [6:0] bcd_decode(logic [7:0] b);
      int sum;
      sum = b[3:0] + (b[4] ? 10 : 0) + (b[5] ? 20 : 0) + (b[6] ? 40 : 0);
      return 7'(sum);
    endfunction

    // Put one bit on the pin; true once the byte is through.
    function bit shift_out(logic [7:0] b);
      io_lvl  = b[bit_cnt[2:0]];
      bit_cnt = bit_cnt + 4'd1;
      return bit_cnt >= 4'd8;
    endfunction

    function void note_word(in_word_t w);
      out_word_t  e;
      logic       fin, fin_rd;
      logic [7:0] fin_addr;
      fin = 0; fin_rd = 0; fin_addr = '0;
      n_in++;
      case (w.op)
        OP_READ_REQ: begin
          rd_pend      = 1;
          rd_pend_addr = w.address;
        end
        OP_WRITE_REQ: begin
          wr_pend      = 1;
          wr_pend_addr = w.address;
          wr_pend_byte = bcd_encode(w.write_value);
        end
        OP_GRANT: begin
          if (!wr_busy && !rd_busy) begin
            if (rd_pend) begin
              rd_pend  = 0;
              rd_busy  = 1;
              cur_addr = rd_pend_addr;
            end else if (wr_pend) begin
              wr_pend  = 0;
              wr_busy  = 1;
              cur_addr = wr_pend_addr;
              cur_byte = wr_pend_byte;
            end
          end
        end
        OP_TICK: begin
          if (wr_busy) begin
            if (bit_cnt >= 4'd8) begin
              bit_cnt = '0; wr_busy = 0; addr_sent = 0; ce_lvl = 0;
              fin = 1; fin_addr = cur_addr;
            end else if (!sck_lvl) begin
              ce_lvl = 1;
              if (!addr_sent) begin
                if (shift_out(cur_addr)) begin
                  bit_cnt   = '0;
                  addr_sent = 1;
                end
              end else begin
                void'(shift_out(cur_byte));
              end
            end
            sck_lvl = !sck_lvl;
          end else if (rd_busy) begin
            if (!sck_lvl) begin
              ce_lvl = 1;
              if (!addr_sent) begin
                if (shift_out(cur_addr)) begin
                  bit_cnt   = '0;
                  addr_sent = 1;
                end
              end else begin
                drv_en = 0;
                rx_byte[bit_cnt[2:0]] = w.io_in;
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8) begin
                  bit_cnt = '0; addr_sent = 0; rd_busy = 0; drv_en = 1; ce_lvl = 0;
                  fin = 1; fin_rd = 1; fin_addr = cur_addr;
                end
              end
            end
            sck_lvl = !sck_lvl;
          end
        end
      endcase
      if (fin) begin
        if (fin_rd) n_rd_done++;
        else n_wr_done++;
      end
      e.sck          = sck_lvl;
      e.io_out       = io_lvl;
      e.io_drive     = drv_en;
      e.chip_enable  = ce_lvl;
      e.writing      = wr_busy;
      e.reading      = rd_busy;
      e.done_res     = fin;
      e.done_is_read = fin_rd;
      e.done_address = fin_addr;
      e.read_raw     = rx_byte;
      e.read_value   = bcd_decode(rx_byte);
      expected_q.push_back(e);
    endfunction

    function void cmp_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t e;
      n_out++;
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp_field("sck", e.sck, got.sck);
      cmp_field("io_out", e.io_out, got.io_out);
      cmp_field("io_drive", e.io_drive, got.io_drive);
      cmp_field("chip_enable", e.chip_enable, got.chip_enable);
      cmp_field("writing", e.writing, got.writing);
      cmp_field("reading", e.reading, got.reading);
      cmp_field("done_res", e.done_res, got.done_res);
      cmp_field("done_is_read", e.done_is_read, got.done_is_read);
      cmp_field("done_address", e.done_address, got.done_address);
      cmp_field("read_raw", e.read_raw, got.read_raw);
      cmp_field("read_value", e.read_value, got.read_value);
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  rtc_scoreboard sb;
  int            cycles;
  bit            tx_calm, rx_calm;
  int            rx_gap, rx_count;

  three_wire_rtc_serial_master_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Wait draw per word; now and then flip into a stretch without gaps.
  function automatic int pick_gap(inout bit calm);
    if ($urandom_range(0, 63) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic in_word_t pack_word(op_t op, logic [7:0] a, logic [6:0] v, logic io);
    in_word_t w;
    w.op          = op;
    w.address     = a;
    w.write_value = v;
    w.io_in       = io;
    return w;
  endfunction

  function automatic in_word_t any_word();
    return pack_word(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [6:0] pick_value();
    if ($urandom_range(0, 7) == 0) return 7'($urandom_range(80, 127));
    return 7'($urandom_range(0, 79));
  endfunction

  // Called and returns at a falling edge.
  task automatic send_word(in_word_t w);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_word(w);
    @(negedge clk);
  endtask

  task automatic tick_word();
    send_word(pack_word(OP_TICK, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                        1'($urandom_range(0, 1))));
  endtask

  task automatic run_transfer();
    bit want_wr, want_rd;
    want_wr = $urandom_range(0, 1);
    want_rd = !want_wr || $urandom_range(0, 1);
    if (want_wr) begin
      send_word(pack_word(OP_WRITE_REQ, 8'($urandom_range(0, 255)), pick_value(), 1'b0));
      if ($urandom_range(0, 9) == 0)
        send_word(pack_word(OP_WRITE_REQ, 8'($urandom_range(0, 255)), pick_value(), 1'b1));
    end
    if (want_rd) begin
      send_word(pack_word(OP_READ_REQ, 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, 127)), 1'($urandom_range(0, 1))));
      if ($urandom_range(0, 9) == 0)
        send_word(pack_word(OP_READ_REQ, 8'($urandom_range(0, 255)), 7'd0, 1'b0));
    end
    send_word(pack_word(OP_GRANT, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                        1'($urandom_range(0, 1))));
    while (sb.wr_busy || sb.rd_busy) begin
      if ($urandom_range(0, 19) == 0) send_word(any_word());
      else tick_word();
    end
  endtask

  initial begin
    sb        = new();
    cycles    = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    tx_calm   = 0;
    rx_calm   = 0;
    rx_count  = 0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    fork
      forever begin
        rx_gap = pick_gap(rx_calm);
        // one long hold-off so the block backs up into its input
        if (rx_count == HOLD_AFTER) rx_gap = HOLD_LEN;
        if (rx_gap > 0) begin
          out_stall <= 1'b1;
          repeat (rx_gap) @(negedge clk);
        end
        out_stall <= 1'b0;
        do @(posedge clk); while (!(out_valid && !out_stall));
        sb.check_word(out_data);
        rx_count++;
        @(negedge clk);
      end
    join_none

    // directed: idle tick, empty grant, out-of-range and edge values,
    // slot overwrite, read preferred over write, grant while busy
    send_word(pack_word(OP_TICK, 8'hFF, 7'h7F, 1'b1));
    send_word(pack_word(OP_GRANT, 8'h00, 7'h00, 1'b0));
    send_word(pack_word(OP_WRITE_REQ, 8'hFF, 7'd127, 1'b1));
    send_word(pack_word(OP_WRITE_REQ, 8'hA5, 7'd79, 1'b0));
    send_word(pack_word(OP_WRITE_REQ, 8'h00, 7'd0, 1'b0));
    send_word(pack_word(OP_READ_REQ, 8'h00, 7'd0, 1'b0));
    send_word(pack_word(OP_READ_REQ, 8'h81, 7'h7F, 1'b1));
    send_word(pack_word(OP_GRANT, 8'hFF, 7'h7F, 1'b1));
    send_word(pack_word(OP_GRANT, 8'h00, 7'h00, 1'b0));
    send_word(pack_word(OP_READ_REQ, 8'h3C, 7'd45, 1'b0));
    for (int i = 0; i < 14; i++)
      send_word(pack_word(OP_TICK, 8'h00, 7'h00, 1'(i[1])));

    while (sb.n_in < N_ITEMS) begin
      while (sb.wr_busy || sb.rd_busy) tick_word();
      if ($urandom_range(0, 99) < 80) begin
        run_transfer();
      end else begin
        repeat ($urandom_range(1, 4)) send_word(any_word());
      end
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d input words, checked %0d result words.", sb.n_in, sb.n_out);
    $display("Transfers finished: %0d writes, %0d reads.", sb.n_wr_done, sb.n_rd_done);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
